// ----- sv/dpa_pkg.sv -----
// Shared types, constants and helpers for the pointer accelerator.
package dpa_pkg;

  localparam int DIR_IN_W  = 3;
  localparam int ANALOG_W  = 12;
  localparam int FRAC_W    = 9;
  localparam int SIZE_W    = 11;
  localparam int HOLD_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [HOLD_W-1:0] HOLD_LIMIT = 4'd15;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  typedef logic signed [1:0] dir_t;

  localparam dir_t DIR_POS = 2'sb01;
  localparam dir_t DIR_NEG = 2'sb11;
  localparam dir_t DIR_NONE = 2'sb00;

  // Saturate a summed direction to -1..1.
  function automatic dir_t clamp_dir(input logic signed [DIR_IN_W-1:0] d);
    dir_t r;
    if (d > 3'sd1) begin
      r = DIR_POS;
    end else if (d < -3'sd1) begin
      r = DIR_NEG;
    end else begin
      r = d[1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/dpad_pointer_accelerator.sv -----
// Top level of the pointer accelerator: input stage, cursor state and result register.
//
//   port group  dir  handshake            carries
//   in_*        in   in_valid / in_stall  dir_x dir_y analog_x analog_y mouse_x mouse_y
//   out_*       out  out_valid/out_stall  cursor_x cursor_y position_written
//   cfg_*       in   cfg_valid/cfg_ready  cfg_index cfg_data (screen width, height)
//
// Each word is captured in an input register and resolved from there into the result
// register; one word is accepted every cycle while the output does not stall.
// The cursor state feeds back combinationally through the step logic.
// Synchronous reset clears the handshake state, the seed flag, hold count and remainders.
// A stall on the output holds the result register, then the input register, then in_stall.
module dpad_pointer_accelerator #(
  parameter int MAX_SPEED  = 8,
  parameter int RAMP_TICKS = 10,
  parameter int COORD_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dpa_pkg::DIR_IN_W-1:0]    dir_x,
  input  logic signed [dpa_pkg::DIR_IN_W-1:0]    dir_y,
  input  logic signed [dpa_pkg::ANALOG_W-1:0]    analog_x,
  input  logic signed [dpa_pkg::ANALOG_W-1:0]    analog_y,
  input  logic [COORD_BITS-1:0]                  mouse_x,
  input  logic [COORD_BITS-1:0]                  mouse_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [COORD_BITS-1:0]                  cursor_x,
  output logic [COORD_BITS-1:0]                  cursor_y,
  output logic                                   position_written,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dpa_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dpa_pkg::SIZE_W-1:0]             cfg_data
);

  localparam int SPEED_W = $clog2(MAX_SPEED + 1);
  localparam int HOLD_N  = 1 << dpa_pkg::HOLD_W;

  // configuration
  logic [dpa_pkg::SIZE_W-1:0] screen_width;
  logic [dpa_pkg::SIZE_W-1:0] screen_height;

  // input register
  logic                                 s1_valid;
  logic signed [dpa_pkg::DIR_IN_W-1:0]  s1_dir_x;
  logic signed [dpa_pkg::DIR_IN_W-1:0]  s1_dir_y;
  logic signed [dpa_pkg::ANALOG_W-1:0]  s1_analog_x;
  logic signed [dpa_pkg::ANALOG_W-1:0]  s1_analog_y;
  logic [COORD_BITS-1:0]                s1_mouse_x;
  logic [COORD_BITS-1:0]                s1_mouse_y;

  // cursor state
  logic [COORD_BITS-1:0]              pos_x;
  logic [COORD_BITS-1:0]              pos_y;
  logic                               seeded;
  logic [dpa_pkg::HOLD_W-1:0]         hold_count;
  logic [dpa_pkg::HOLD_W-1:0]         hold_count_next;
  logic signed [dpa_pkg::FRAC_W-1:0]  frac_x;
  logic signed [dpa_pkg::FRAC_W-1:0]  frac_y;

  logic                               s1_go;
  logic                               s1_fire;
  logic                               in_fire;
  dpa_pkg::dir_t                      dx;
  dpa_pkg::dir_t                      dy;
  logic                               dir_held;
  logic                               idle;
  logic [dpa_pkg::SIZE_W-1:0]         half_w;
  logic [dpa_pkg::SIZE_W-1:0]         half_h;
  logic [COORD_BITS-1:0]              seed_x;
  logic [COORD_BITS-1:0]              seed_y;
  logic [COORD_BITS-1:0]              cur_x;
  logic [COORD_BITS-1:0]              cur_y;
  logic [COORD_BITS-1:0]              new_x;
  logic [COORD_BITS-1:0]              new_y;
  logic signed [dpa_pkg::FRAC_W-1:0]  new_frac_x;
  logic signed [dpa_pkg::FRAC_W-1:0]  new_frac_y;
  logic [SPEED_W-1:0]                 speed;
  logic [SPEED_W-1:0]                 speed_tab [HOLD_N];

  // Ramp table: 1 + hold * (MAX_SPEED - 1) / RAMP_TICKS, saturated at MAX_SPEED.
  for (genvar h = 0; h < HOLD_N; h++) begin : g_speed
    localparam int RAW = 1 + (h * (MAX_SPEED - 1)) / RAMP_TICKS;
    localparam int SP  = (RAW > MAX_SPEED) ? MAX_SPEED : RAW;
    assign speed_tab[h] = SPEED_W'(SP);
  end

  assign cfg_ready = 1'b1;

  assign s1_go    = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_go;
  assign in_stall = s1_valid && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  assign dx       = dpa_pkg::clamp_dir(s1_dir_x);
  assign dy       = dpa_pkg::clamp_dir(s1_dir_y);
  assign dir_held = (dx != dpa_pkg::DIR_NONE) || (dy != dpa_pkg::DIR_NONE);
  assign idle     = !dir_held && (s1_analog_x == '0) && (s1_analog_y == '0);

  // Seed from the mouse, or from the screen center when the mouse coordinate is zero.
  assign half_w = {1'b0, screen_width[dpa_pkg::SIZE_W-1:1]};
  assign half_h = {1'b0, screen_height[dpa_pkg::SIZE_W-1:1]};
  assign seed_x = (s1_mouse_x != '0) ? s1_mouse_x : COORD_BITS'(half_w);
  assign seed_y = (s1_mouse_y != '0) ? s1_mouse_y : COORD_BITS'(half_h);
  assign cur_x  = seeded ? pos_x : seed_x;
  assign cur_y  = seeded ? pos_y : seed_y;

  assign speed = speed_tab[hold_count];

  always_comb begin
    if (!dir_held) begin
      hold_count_next = '0;
    end else if (hold_count == dpa_pkg::HOLD_LIMIT) begin
      hold_count_next = hold_count;
    end else begin
      hold_count_next = hold_count + 1'b1;
    end
  end

  dpa_axis #(
    .COORD_BITS(COORD_BITS),
    .SPEED_W   (SPEED_W)
  ) u_axis_x (
    .pos_cur (cur_x),
    .dir     (dx),
    .speed   (speed),
    .analog  (s1_analog_x),
    .frac    (frac_x),
    .size    (screen_width),
    .pos_new (new_x),
    .frac_new(new_frac_x)
  );

  dpa_axis #(
    .COORD_BITS(COORD_BITS),
    .SPEED_W   (SPEED_W)
  ) u_axis_y (
    .pos_cur (cur_y),
    .dir     (dy),
    .speed   (speed),
    .analog  (s1_analog_y),
    .frac    (frac_y),
    .size    (screen_height),
    .pos_new (new_y),
    .frac_new(new_frac_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= dpa_pkg::WIDTH_RESET;
      screen_height <= dpa_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpa_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        dpa_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_dir_x    <= dir_x;
      s1_dir_y    <= dir_y;
      s1_analog_x <= analog_x;
      s1_analog_y <= analog_y;
      s1_mouse_x  <= mouse_x;
      s1_mouse_y  <= mouse_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded     <= 1'b0;
      hold_count <= '0;
      frac_x     <= '0;
      frac_y     <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
    end else if (s1_fire) begin
      seeded     <= 1'b1;
      hold_count <= hold_count_next;
      // Idle word: drop the remainders and keep the position unclamped.
      frac_x     <= idle ? '0 : new_frac_x;
      frac_y     <= idle ? '0 : new_frac_y;
      pos_x      <= idle ? cur_x : new_x;
      pos_y      <= idle ? cur_y : new_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      cursor_x         <= idle ? cur_x : new_x;
      cursor_y         <= idle ? cur_y : new_y;
      position_written <= !seeded || !idle;
    end
  end

`ifndef SYNTHESIS
  a_seed_after_word: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> seeded)
    else $error("seed flag not set after a word");

  a_idle_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && idle |=> (hold_count == '0) && (frac_x == '0) && (frac_y == '0))
    else $error("idle word did not clear hold count and remainders");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("result register not loaded after a word");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled while the pipeline has room");
`endif

endmodule

// ----- sv/dpa_axis.sv -----
// One axis of the position update: direction step, analog remainder, screen clamp.
module dpa_axis #(
  parameter int COORD_BITS = 10,
  parameter int SPEED_W    = 4
) (
  input  logic [COORD_BITS-1:0]                   pos_cur,
  input  dpa_pkg::dir_t                           dir,
  input  logic [SPEED_W-1:0]                      speed,
  input  logic signed [dpa_pkg::ANALOG_W-1:0]     analog,
  input  logic signed [dpa_pkg::FRAC_W-1:0]       frac,
  input  logic [dpa_pkg::SIZE_W-1:0]              size,
  output logic [COORD_BITS-1:0]                   pos_new,
  output logic signed [dpa_pkg::FRAC_W-1:0]       frac_new
);

  localparam int LW = ((COORD_BITS > dpa_pkg::SIZE_W) ? COORD_BITS : dpa_pkg::SIZE_W) + 2;
  localparam logic [LW-1:0] COORD_MAX = LW'((64'd1 << COORD_BITS) - 64'd1);

  logic signed [12:0]   sum;
  logic [11:0]          mag;
  logic [3:0]           whole_mag;
  logic signed [LW-1:0] whole;
  logic signed [LW-1:0] step;
  logic signed [LW-1:0] nx;
  logic [LW-1:0]        lim;
  logic [LW-1:0]        lim_c;
  logic [LW-1:0]        clamped;

  // Remainder plus velocity; the whole part truncates toward zero.
  assign sum       = {{4{frac[dpa_pkg::FRAC_W-1]}}, frac} + {analog[dpa_pkg::ANALOG_W-1], analog};
  assign mag       = sum[12] ? 12'(-sum) : sum[11:0];
  assign whole_mag = mag[11:8];
  assign whole     = sum[12] ? -LW'(whole_mag) : LW'(whole_mag);
  assign frac_new  = sum[12] ? -{1'b0, mag[7:0]} : {1'b0, mag[7:0]};

  always_comb begin
    case (dir)
      dpa_pkg::DIR_POS: step = LW'(speed);
      dpa_pkg::DIR_NEG: step = -LW'(speed);
      default:          step = '0;
    endcase
  end

  assign nx = LW'(pos_cur) + step + whole;

  assign lim   = (size == '0) ? '0 : (LW'(size) - LW'(1));
  assign lim_c = (lim > COORD_MAX) ? COORD_MAX : lim;

  always_comb begin
    if (nx[LW-1]) begin
      clamped = '0;
    end else if (nx > lim_c) begin
      clamped = lim_c;
    end else begin
      clamped = nx;
    end
  end

  assign pos_new = COORD_BITS'(clamped);

endmodule
